// ===== sv/char_lcd_terminal_nibble_sequencer_core_assert.svh =====
// Assertion macros shared by the sequencer modules.
`ifndef CHAR_LCD_TERMINAL_NIBBLE_SEQUENCER_CORE_ASSERT_SVH
`define CHAR_LCD_TERMINAL_NIBBLE_SEQUENCER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define CLNS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sequencer assertion failed");
// Next-cycle implication, disabled during reset
`define CLNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sequencer assertion failed");
`else
`define CLNS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define CLNS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/clns_pkg.sv =====
package clns_pkg;

	// Terminal operation codes
	localparam logic [2:0] OP_PRINT   = 3'd0;
	localparam logic [2:0] OP_GOTO    = 3'd1;
	localparam logic [2:0] OP_CLEAR   = 3'd2;
	localparam logic [2:0] OP_HOME    = 3'd3;
	localparam logic [2:0] OP_DISPLAY = 3'd4;
	localparam logic [2:0] OP_MOVE    = 3'd5;
	localparam logic [2:0] OP_SHIFT   = 3'd6;

	// Character codes
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	// LCD instruction bytes
	localparam logic [7:0] CMD_CLEAR        = 8'h01;
	localparam logic [7:0] CMD_HOME         = 8'h02;
	localparam logic [7:0] CMD_CURSOR_LEFT  = 8'h10;
	localparam logic [7:0] CMD_CURSOR_RIGHT = 8'h14;
	localparam logic [7:0] CMD_SHIFT_LEFT   = 8'h18;
	localparam logic [7:0] CMD_SHIFT_RIGHT  = 8'h1C;
	localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;

	// DDRAM line bases
	localparam logic [6:0] LINE1_BASE = 7'h40;
	localparam logic [6:0] BASE_W12   = 7'h0C;
	localparam logic [6:0] BASE_W16   = 7'h10;
	localparam logic [6:0] BASE_W20   = 7'h14;

	// Configuration register indexes
	localparam logic [1:0] REG_LINE_COUNT   = 2'd0;
	localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
	localparam logic [1:0] REG_BACKLIGHT    = 2'd2;

	// Byte source select
	typedef logic [1:0] sel_t;
	localparam sel_t SEL_PAD  = 2'd0;
	localparam sel_t SEL_CHAR = 2'd1;
	localparam sel_t SEL_NEXT = 2'd2;
	localparam sel_t SEL_CMD  = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic load_item;
		logic load_pad;
		logic dec_pad;
		logic emit;
		sel_t sel;
		logic phase;
		logic last;
		logic step_char;
		logic apply_next;
		logic apply_cmd;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic newline;
		logic print_char;
		logic cmd_go;
		logic pad_none;
		logic pad_one;
		logic wrap;
		logic slot_free;
	} dp_stat_t;

	// Display on/off control byte for each mode
	function automatic logic [7:0] display_code(input logic [1:0] mode);
		logic [7:0] code;
		case (mode)
			2'd0: code = 8'h0F;
			2'd1: code = 8'h0E;
			2'd2: code = 8'h0C;
			default: code = 8'h08;
		endcase
		return code;
	endfunction

	// DDRAM base address of a line at the given width
	function automatic logic [6:0] line_base(input logic [1:0] line, input logic [4:0] cols);
		logic [6:0] b2;
		logic [6:0] base;
		if (cols == 5'd12) begin
			b2 = BASE_W12;
		end else if (cols == 5'd16) begin
			b2 = BASE_W16;
		end else begin
			b2 = BASE_W20;
		end
		case (line)
			2'd0: base = 7'h00;
			2'd1: base = LINE1_BASE;
			2'd2: base = b2;
			default: base = b2 | LINE1_BASE;
		endcase
		return base;
	endfunction

endpackage

// ===== sv/clns_regs.sv =====
module clns_regs import clns_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [2:0]  line_count,
	output logic [4:0]  column_count,
	output logic        backlight_on
);

	logic [2:0] line_count_q;
	logic [4:0] column_count_q;
	logic       backlight_q;
	logic [1:0] reg_index;
	logic       wr_en;

	assign reg_index = paddr[3:2];
	assign wr_en     = psel & penable & pwrite;
	assign pready    = 1'b1;

	// Write registers on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q   <= 3'd2;
			column_count_q <= 5'd16;
			backlight_q    <= 1'b1;
		end else if (wr_en) begin
			case (reg_index)
				REG_LINE_COUNT:   line_count_q   <= pwdata[2:0];
				REG_COLUMN_COUNT: column_count_q <= pwdata[4:0];
				REG_BACKLIGHT:    backlight_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_index)
			REG_LINE_COUNT:   prdata = {29'd0, line_count_q};
			REG_COLUMN_COUNT: prdata = {27'd0, column_count_q};
			REG_BACKLIGHT:    prdata = {31'd0, backlight_q};
			default:          prdata = 32'd0;
		endcase
	end

	assign line_count   = line_count_q;
	assign column_count = column_count_q;
	assign backlight_on = backlight_q;

endmodule

// ===== sv/clns_dp.sv =====
`include "char_lcd_terminal_nibble_sequencer_core_assert.svh"
module clns_dp import clns_pkg::*; #(
	parameter int MAX_COLUMNS = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [2:0] line_count,
	input  logic [4:0] column_count,
	input  logic       backlight_on,
	input  logic [2:0] operation,
	input  logic [7:0] character,
	input  logic [1:0] target_line,
	input  logic [4:0] target_column,
	input  logic [1:0] display_mode,
	input  logic       move_right,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	output logic       result_valid,
	output logic [7:0] expander_byte,
	output logic       last,
	input  logic       result_ready
);

	localparam logic [4:0] MaxCols = 5'(MAX_COLUMNS);

	// Latched item
	logic [2:0] op_q;
	logic [7:0] ch_q;
	logic [1:0] tl_q;
	logic [4:0] tc_q;
	logic [1:0] dm_q;
	logic       right_q;

	// Cursor and pad counter
	logic [1:0] line_q;
	logic [4:0] col_q;
	logic [4:0] pad_q;

	// Output stage
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic [4:0] cols_eff;
	logic [2:0] lines_eff;
	logic       wide_ok;
	logic [4:0] col_inc;
	logic [2:0] line_inc;
	logic [1:0] next_line;
	logic       goto_ok;
	logic       move_ok;
	logic [6:0] goto_addr;
	logic       cmd_go;
	logic [7:0] cmd_byte;
	logic [7:0] next_byte;
	logic [4:0] pad_init;
	logic [7:0] byte_val;
	logic       rs;
	logic [3:0] nibble;

	// Clamp the geometry registers
	always_comb begin
		if (column_count == 5'd0) begin
			cols_eff = 5'd1;
		end else if (column_count > MaxCols) begin
			cols_eff = MaxCols;
		end else begin
			cols_eff = column_count;
		end
		wide_ok = (cols_eff == 5'd12) || (cols_eff == 5'd16) || (cols_eff == 5'd20);
		if ((line_count >= 3'd4) && wide_ok) begin
			lines_eff = 3'd4;
		end else if (line_count >= 3'd2) begin
			lines_eff = 3'd2;
		end else begin
			lines_eff = 3'd1;
		end
	end

	// Cursor arithmetic
	assign col_inc   = col_q + 5'd1;
	assign line_inc  = {1'b0, line_q} + 3'd1;
	assign next_line = (line_inc >= lines_eff) ? 2'd0 : line_inc[1:0];
	assign goto_ok   = ({1'b0, tl_q} < lines_eff) && (tc_q < cols_eff);
	assign move_ok   = right_q ? (({1'b0, col_q} + 6'd1) < {1'b0, cols_eff}) : (col_q != 5'd0);
	assign goto_addr = line_base(tl_q, cols_eff) + {2'b00, tc_q};
	assign next_byte = CMD_SET_DDRAM | {1'b0, line_base(next_line, cols_eff)};
	assign pad_init  = (col_q < cols_eff) ? (cols_eff - col_q) : 5'd0;

	// Single-byte command decode
	always_comb begin
		case (op_q)
			OP_GOTO: begin
				cmd_go   = goto_ok;
				cmd_byte = CMD_SET_DDRAM | {1'b0, goto_addr};
			end
			OP_CLEAR: begin
				cmd_go   = 1'b1;
				cmd_byte = CMD_CLEAR;
			end
			OP_HOME: begin
				cmd_go   = 1'b1;
				cmd_byte = CMD_HOME;
			end
			OP_DISPLAY: begin
				cmd_go   = 1'b1;
				cmd_byte = display_code(dm_q);
			end
			OP_MOVE: begin
				cmd_go   = move_ok;
				cmd_byte = right_q ? CMD_CURSOR_RIGHT : CMD_CURSOR_LEFT;
			end
			OP_SHIFT: begin
				cmd_go   = 1'b1;
				cmd_byte = right_q ? CMD_SHIFT_RIGHT : CMD_SHIFT_LEFT;
			end
			default: begin
				cmd_go   = 1'b0;
				cmd_byte = CMD_CLEAR;
			end
		endcase
	end

	assign stat.cmd_go     = cmd_go;
	assign stat.newline    = (op_q == OP_PRINT) && (ch_q == CHAR_NEWLINE);
	assign stat.print_char = (op_q == OP_PRINT) && (ch_q != CHAR_NEWLINE);
	assign stat.pad_none   = (pad_init == 5'd0);
	assign stat.pad_one    = (pad_q == 5'd1);
	assign stat.wrap       = (col_inc >= cols_eff);
	assign stat.slot_free  = !out_valid_q || result_ready;

	// Select the byte and its nibble
	always_comb begin
		case (cmd.sel)
			SEL_PAD: begin
				byte_val = CHAR_SPACE;
				rs       = 1'b1;
			end
			SEL_CHAR: begin
				byte_val = ch_q;
				rs       = 1'b1;
			end
			SEL_NEXT: begin
				byte_val = next_byte;
				rs       = 1'b0;
			end
			default: begin
				byte_val = cmd_byte;
				rs       = 1'b0;
			end
		endcase
		nibble = cmd.phase ? byte_val[3:0] : byte_val[7:4];
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q    <= operation;
			ch_q    <= character;
			tl_q    <= target_line;
			tc_q    <= target_column;
			dm_q    <= display_mode;
			right_q <= move_right;
		end
	end

	// Advance the cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= 2'd0;
			col_q  <= 5'd0;
		end else if (cmd.step_char) begin
			col_q <= col_inc;
		end else if (cmd.apply_next) begin
			line_q <= next_line;
			col_q  <= 5'd0;
		end else if (cmd.apply_cmd) begin
			case (op_q)
				OP_GOTO: begin
					line_q <= tl_q;
					col_q  <= tc_q;
				end
				OP_CLEAR, OP_HOME: begin
					line_q <= 2'd0;
					col_q  <= 5'd0;
				end
				OP_MOVE: col_q <= right_q ? col_inc : (col_q - 5'd1);
				default: ;
			endcase
		end
	end

	// Count down the newline padding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q <= 5'd0;
		end else if (cmd.load_pad) begin
			pad_q <= pad_init;
		end else if (cmd.dec_pad) begin
			pad_q <= pad_q - 5'd1;
		end
	end

	// Output register: load on emit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			byte_q <= {nibble, backlight_on, 2'b00, rs};
			last_q <= cmd.last;
		end
	end

	assign result_valid  = out_valid_q;
	assign expander_byte = byte_q;
	assign last          = last_q;

	`CLNS_ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, cmd.emit, !out_valid_q || result_ready)
	`CLNS_ASSERT_IMPLIES(a_pad_nonzero, clk, arst_n, cmd.emit && (cmd.sel == SEL_PAD), pad_q != 5'd0)
	`CLNS_ASSERT_NEXT(a_next_col_zero, clk, arst_n, cmd.apply_next, col_q == 5'd0)

endmodule

// ===== sv/clns_ctrl.sv =====
`include "char_lcd_terminal_nibble_sequencer_core_assert.svh"
module clns_ctrl import clns_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_PAD   = 3'd2;
	localparam logic [2:0] ST_CHAR  = 3'd3;
	localparam logic [2:0] ST_NEXT  = 3'd4;
	localparam logic [2:0] ST_CMD   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       phase_q;

	// Sequence the LCD bytes of one item
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		cmd        = '0;
		cmd.phase  = phase_q;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_START;
				end
			end
			ST_START: begin
				if (stat.newline) begin
					cmd.load_pad = 1'b1;
					state_d      = stat.pad_none ? ST_NEXT : ST_PAD;
				end else if (stat.print_char) begin
					state_d = ST_CHAR;
				end else if (stat.cmd_go) begin
					state_d = ST_CMD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_PAD: begin
				cmd.sel = SEL_PAD;
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					if (phase_q) begin
						cmd.dec_pad = 1'b1;
						if (stat.pad_one) begin
							state_d = ST_NEXT;
						end
					end
				end
			end
			ST_CHAR: begin
				cmd.sel  = SEL_CHAR;
				cmd.last = phase_q && !stat.wrap;
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					if (phase_q) begin
						cmd.step_char = 1'b1;
						state_d       = stat.wrap ? ST_NEXT : ST_IDLE;
					end
				end
			end
			ST_NEXT: begin
				cmd.sel  = SEL_NEXT;
				cmd.last = phase_q;
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					if (phase_q) begin
						cmd.apply_next = 1'b1;
						state_d        = ST_IDLE;
					end
				end
			end
			ST_CMD: begin
				cmd.sel  = SEL_CMD;
				cmd.last = phase_q;
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					if (phase_q) begin
						cmd.apply_cmd = 1'b1;
						state_d       = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and nibble phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				phase_q <= ~phase_q;
			end
		end
	end

	`CLNS_ASSERT_IMPLIES(a_idle_phase, clk, arst_n, state_q == ST_IDLE, !phase_q)
	`CLNS_ASSERT_NEXT(a_nibble_pair, clk, arst_n, cmd.emit && !phase_q, state_q == $past(state_q))
	`CLNS_ASSERT_NEXT(a_start_once, clk, arst_n, state_q == ST_START, state_q != ST_START)

endmodule

// ===== sv/char_lcd_terminal_nibble_sequencer_core.sv =====
// Channel  | Handshake                   | Payload
// item     | item_valid / item_ready     | operation, character, target_line,
//          |                             | target_column, display_mode, move_right
// result   | result_valid / result_ready | expander_byte, last
// config   | psel, penable, pwrite       | paddr, pwdata, prdata (pready tied high)
//
// One item at a time: accept, decode, then each LCD byte as two nibbles, high nibble first.
// A newline sends up to MAX_COLUMNS pad spaces, then the next line's address.
// The single output register paces the nibbles; a stalled result_ready holds the sequencer.
// Items that send nothing go from START straight back to IDLE and ready.
// Reset is asynchronous, active low: cursor at line 0 column 0, 2 lines, 16 columns,
// backlight on.
module char_lcd_terminal_nibble_sequencer_core import clns_pkg::*; #(
	parameter int MAX_COLUMNS = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  operation,
	input  logic [7:0]  character,
	input  logic [1:0]  target_line,
	input  logic [4:0]  target_column,
	input  logic [1:0]  display_mode,
	input  logic        move_right,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  expander_byte,
	output logic        last
);

	logic [2:0] line_count;
	logic [4:0] column_count;
	logic       backlight_on;
	dp_cmd_t    cmd;
	dp_stat_t   stat;

	clns_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.line_count   (line_count),
		.column_count (column_count),
		.backlight_on (backlight_on)
	);

	clns_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	clns_dp #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.line_count    (line_count),
		.column_count  (column_count),
		.backlight_on  (backlight_on),
		.operation     (operation),
		.character     (character),
		.target_line   (target_line),
		.target_column (target_column),
		.display_mode  (display_mode),
		.move_right    (move_right),
		.cmd           (cmd),
		.stat          (stat),
		.result_valid  (result_valid),
		.expander_byte (expander_byte),
		.last          (last),
		.result_ready  (result_ready)
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import clns_pkg::*;

	localparam int MAX_COLUMNS = 20;
	localparam int SEGMENTS = 6;
	localparam int ITEMS_PER_SEGMENT = 28;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 100000;
	localparam int LONG_STALL_CYCLES = 400;
	localparam int TIMEOUT_NS = 3000000;

	// Codes not covered by the package
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam logic [1:0] MODE_BLINK = 2'd0;
	localparam logic [1:0] MODE_CURSOR = 2'd1;
	localparam logic [1:0] MODE_PLAIN = 2'd2;
	localparam logic [1:0] MODE_OFF = 2'd3;
	localparam logic [7:0] DISP_BLINK = 8'h0F;
	localparam logic [7:0] DISP_CURSOR = 8'h0E;
	localparam logic [7:0] DISP_PLAIN = 8'h0C;
	localparam logic [7:0] DISP_OFF = 8'h08;
	localparam bit TYPED = 1'b1;
	localparam bit PREDICTED = 1'b0;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] char_code;
		logic [1:0] line;
		logic [4:0] column;
		logic [1:0] mode;
		logic       right;
	} term_cmd_t;

	typedef struct packed {
		logic       is_last;
		logic [7:0] xbyte;
	} nibble_t;

	// One row of the directed plan: either a register write or a command
	typedef struct packed {
		logic       is_cfg;
		logic [1:0] reg_index;
		logic [4:0] reg_value;
		term_cmd_t  cmd;
		logic       typed;
		logic [7:0] hi;
		logic [7:0] lo;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [2:0]  operation = '0;
	logic [7:0]  character = '0;
	logic [1:0]  target_line = '0;
	logic [4:0]  target_column = '0;
	logic [1:0]  display_mode = '0;
	logic        move_right = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [7:0]  expander_byte;
	logic        last;

	// Predictor state, mirrors the block after reset
	logic [2:0] cfg_lines = 3'd2;
	logic [4:0] cfg_cols = 5'd16;
	logic       cfg_backlight = 1'b1;
	logic [1:0] cur_line = '0;
	logic [4:0] cur_col = '0;

	nibble_t     predicted[$];
	nibble_t     pending_nibbles[$];
	plan_row_t   directed_plan[$];
	int unsigned failures = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned stall_asks = 0;
	int unsigned stall_served = 0;
	int unsigned stall_left = 0;

	char_lcd_terminal_nibble_sequencer_core #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.operation(operation),
		.character(character),
		.target_line(target_line),
		.target_column(target_column),
		.display_mode(display_mode),
		.move_right(move_right),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.expander_byte(expander_byte),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Clamp the width register the way the block does
	function automatic int unsigned active_columns();
		if (cfg_cols == 0) return 1;
		if (cfg_cols > MAX_COLUMNS) return MAX_COLUMNS;
		return cfg_cols;
	endfunction

	// Four lines only exist at widths 12, 16 and 20
	function automatic int unsigned active_lines();
		int unsigned n;
		int unsigned w;
		n = (cfg_lines == 0) ? 1 : ((cfg_lines > 4) ? 4 : cfg_lines);
		w = active_columns();
		if (n == 4 && (w == 12 || w == 16 || w == 20)) return 4;
		return (n >= 2) ? 2 : 1;
	endfunction

	function automatic logic [6:0] ddram_base(logic [1:0] line);
		logic [6:0] third_base;
		logic [6:0] base;
		case (active_columns())
			12: third_base = BASE_W12;
			16: third_base = BASE_W16;
			default: third_base = BASE_W20;
		endcase
		case (line)
			2'd0: base = 7'h00;
			2'd1: base = LINE1_BASE;
			2'd2: base = third_base;
			default: base = third_base + LINE1_BASE;
		endcase
		return base;
	endfunction

	// Split one LCD byte into two expander bytes, high nibble first
	function automatic void lcd_send(logic [7:0] value, logic rs);
		nibble_t n;
		n.is_last = 1'b0;
		n.xbyte = {value[7:4], cfg_backlight, 2'b00, rs};
		predicted.push_back(n);
		n.xbyte = {value[3:0], cfg_backlight, 2'b00, rs};
		predicted.push_back(n);
	endfunction

	// Move to column 0 of the next line and resend its address
	function automatic void advance_line();
		int unsigned nl;
		nl = cur_line + 1;
		if (nl >= active_lines()) nl = 0;
		cur_line = nl[1:0];
		cur_col = '0;
		lcd_send(CMD_SET_DDRAM | {1'b0, ddram_base(nl[1:0])}, 1'b0);
	endfunction

	// Work out the expander bytes of one terminal command and advance the cursor
	function automatic void predict_command(term_cmd_t c);
		int unsigned w;
		int unsigned pad;
		logic [6:0] addr;
		nibble_t tail;
		w = active_columns();
		predicted.delete();
		case (c.op)
			OP_PRINT: begin
				if (c.char_code == CHAR_NEWLINE) begin
					pad = (cur_col < w) ? w - cur_col : 0;
					repeat (pad) lcd_send(CHAR_SPACE, 1'b1);
					advance_line();
				end else begin
					lcd_send(c.char_code, 1'b1);
					cur_col = cur_col + 1'b1;
					if (cur_col >= w) advance_line();
				end
			end
			OP_GOTO: begin
				if (c.line < active_lines() && c.column < w) begin
					cur_line = c.line;
					cur_col = c.column;
					addr = ddram_base(c.line) + c.column;
					lcd_send(CMD_SET_DDRAM | {1'b0, addr}, 1'b0);
				end
			end
			OP_CLEAR: begin
				lcd_send(CMD_CLEAR, 1'b0);
				cur_line = '0;
				cur_col = '0;
			end
			OP_HOME: begin
				lcd_send(CMD_HOME, 1'b0);
				cur_line = '0;
				cur_col = '0;
			end
			OP_DISPLAY: begin
				case (c.mode)
					MODE_BLINK: lcd_send(DISP_BLINK, 1'b0);
					MODE_CURSOR: lcd_send(DISP_CURSOR, 1'b0);
					MODE_PLAIN: lcd_send(DISP_PLAIN, 1'b0);
					default: lcd_send(DISP_OFF, 1'b0);
				endcase
			end
			OP_MOVE: begin
				// saturate at both edges
				if (c.right) begin
					if (cur_col + 1 < w) begin
						cur_col = cur_col + 1'b1;
						lcd_send(CMD_CURSOR_RIGHT, 1'b0);
					end
				end else if (cur_col > 0) begin
					cur_col = cur_col - 1'b1;
					lcd_send(CMD_CURSOR_LEFT, 1'b0);
				end
			end
			OP_SHIFT: lcd_send(c.right ? CMD_SHIFT_RIGHT : CMD_SHIFT_LEFT, 1'b0);
			default: ;
		endcase
		if (predicted.size() != 0) begin
			tail = predicted.pop_back();
			tail.is_last = 1'b1;
			predicted.push_back(tail);
		end
	endfunction

	// Mostly well-formed commands, some invalid gotos, saturating moves and unused codes
	function automatic term_cmd_t random_cmd();
		term_cmd_t c;
		int unsigned pick;
		c.char_code = 8'($urandom_range(255));
		c.line = 2'($urandom_range(3));
		c.column = 5'($urandom_range(31));
		c.mode = 2'($urandom_range(3));
		c.right = 1'($urandom_range(1));
		pick = $urandom_range(99);
		if (pick < 45) begin
			c.op = OP_PRINT;
		end else if (pick < 52) begin
			c.op = OP_PRINT;
			c.char_code = CHAR_NEWLINE;
		end else if (pick < 67) begin
			c.op = OP_GOTO;
			if ($urandom_range(9) != 0) begin
				c.line = 2'($urandom_range(active_lines() - 1));
				c.column = 5'($urandom_range(active_columns() - 1));
			end
		end else if (pick < 70) begin
			c.op = OP_CLEAR;
		end else if (pick < 73) begin
			c.op = OP_HOME;
		end else if (pick < 78) begin
			c.op = OP_DISPLAY;
		end else if (pick < 92) begin
			c.op = OP_MOVE;
		end else if (pick < 97) begin
			c.op = OP_SHIFT;
		end else begin
			c.op = OP_UNUSED;
		end
		return c;
	endfunction

	function automatic void add_cmd(logic [2:0] op, logic [7:0] char_code, logic [1:0] line,
			logic [4:0] column, logic [1:0] mode, logic right, bit typed,
			logic [7:0] hi, logic [7:0] lo);
		plan_row_t row;
		row = '0;
		row.cmd = {op, char_code, line, column, mode, right};
		row.typed = typed;
		row.hi = hi;
		row.lo = lo;
		directed_plan.push_back(row);
	endfunction

	function automatic void add_cfg(logic [1:0] index, logic [4:0] value);
		plan_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.reg_index = index;
		row.reg_value = value;
		directed_plan.push_back(row);
	endfunction

	// Offer one command, wait for its transfer, then queue what it must produce
	task automatic send_cmd(term_cmd_t cmd, bit typed, logic [7:0] hi, logic [7:0] lo);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		operation <= cmd.op;
		character <= cmd.char_code;
		target_line <= cmd.line;
		target_column <= cmd.column;
		display_mode <= cmd.mode;
		move_right <= cmd.right;
		do @(posedge clk); while (!item_ready);
		predict_command(cmd);
		if (typed) begin
			pending_nibbles.push_back({1'b0, hi});
			pending_nibbles.push_back({1'b1, lo});
		end else begin
			foreach (predicted[k]) pending_nibbles.push_back(predicted[k]);
		end
	endtask

	// Stop offering and wait until every expected byte is out and the block is quiet
	task automatic drain_results();
		int unsigned waited;
		waited = 0;
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_nibbles.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_nibbles.size() != 0) begin
			$display("%0t: missing %0d bytes, expected next %h last=%b, actual none",
				$time, pending_nibbles.size(), pending_nibbles[0].xbyte,
				pending_nibbles[0].is_last);
			failures++;
			pending_nibbles.delete();
		end
	endtask

	// Setup cycle, then access cycle; upper data bits carry noise
	task automatic write_reg(logic [1:0] index, logic [4:0] value);
		logic [31:0] word;
		word = $urandom();
		word[4:0] = value;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			REG_LINE_COUNT: cfg_lines = value[2:0];
			REG_COLUMN_COUNT: cfg_cols = value;
			REG_BACKLIGHT: cfg_backlight = value[0];
			default: ;
		endcase
	endtask

	// Receiver: random ready, or a long hold-off when asked
	always @(negedge clk) begin
		if (stall_left != 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (stall_served != stall_asks) begin
			stall_served <= stall_asks;
			stall_left <= LONG_STALL_CYCLES;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Compare each result transfer with the oldest expected byte
	always @(posedge clk) begin : check_nibbles
		nibble_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_nibbles.size() == 0) begin
				$display("%0t: unexpected byte, expected none, actual %h last=%b",
					$time, expander_byte, last);
				failures++;
			end else begin
				want = pending_nibbles.pop_front();
				if (expander_byte !== want.xbyte) begin
					$display("%0t: expander_byte expected %h actual %h",
						$time, want.xbyte, expander_byte);
					failures++;
				end
				if (last !== want.is_last) begin
					$display("%0t: last expected %b actual %b", $time, want.is_last, last);
					failures++;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("== FAIL ==");
		$finish;
	end

	initial begin : main_sequence
		plan_row_t row;
		logic [2:0] lines_val;
		logic [4:0] cols_val;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed plan, starting from the reset settings: 2 lines, 16 columns, backlight on
		add_cmd(OP_CLEAR, 8'h00, 2'd0, 5'd0, MODE_BLINK, 1'b0, TYPED, 8'h08, 8'h18);
		add_cmd(OP_HOME, 8'h00, 2'd0, 5'd0, MODE_BLINK, 1'b0, TYPED, 8'h08, 8'h28);
		add_cmd(OP_DISPLAY, 8'h00, 2'd0, 5'd0, MODE_BLINK, 1'b0, TYPED, 8'h08, 8'hF8);
		add_cmd(OP_DISPLAY, 8'h00, 2'd0, 5'd0, MODE_CURSOR, 1'b0, PREDICTED, 8'h00, 8'h00);
		add_cmd(OP_DISPLAY, 8'h00, 2'd0, 5'd0, MODE_OFF, 1'b0, TYPED, 8'h08, 8'h88);
		add_cmd(OP_SHIFT, 8'h00, 2'd0, 5'd0, MODE_BLINK, 1'b1, TYPED, 8'h18, 8'hC8);
		add_cmd(OP_SHIFT, 8'h00, 2'd0, 5'd0, MODE_BLINK, 1'b0, TYPED, 8'h18, 8'h88);
		// cursor move left at column 0 saturates
		add_cmd(OP_MOVE, 8'h00, 2'd0, 5'd0, MODE_BLINK, 1'b0, PREDICTED, 8'h00, 8'h00);
		add_cmd(OP_PRINT, 8'hFF, 2'd0, 5'd0, MODE_BLINK, 1'b0, TYPED, 8'hF9, 8'hF9);
		add_cmd(OP_PRINT, 8'h00, 2'd0, 5'd0, MODE_BLINK, 1'b0, TYPED, 8'h09, 8'h09);
		add_cmd(OP_MOVE, 8'h00, 2'd0, 5'd0, MODE_BLINK, 1'b1, PREDICTED, 8'h00, 8'h00);
		// newline pads the rest of line 0
		add_cmd(OP_PRINT, CHAR_NEWLINE, 2'd0, 5'd0, MODE_BLINK, 1'b0, PREDICTED, 8'h00, 8'h00);
		add_cmd(OP_GOTO, 8'h00, 2'd1, 5'd15, MODE_BLINK, 1'b0, TYPED, 8'hC8, 8'hF8);
		// move right at the last column saturates, then printing there wraps to line 0
		add_cmd(OP_MOVE, 8'h00, 2'd0, 5'd0, MODE_BLINK, 1'b1, PREDICTED, 8'h00, 8'h00);
		add_cmd(OP_PRINT, 8'h41, 2'd0, 5'd0, MODE_BLINK, 1'b0, PREDICTED, 8'h00, 8'h00);
		// invalid gotos: line not addressable, column at the width
		add_cmd(OP_GOTO, 8'h00, 2'd2, 5'd0, MODE_BLINK, 1'b0, PREDICTED, 8'h00, 8'h00);
		add_cmd(OP_GOTO, 8'h00, 2'd0, 5'd16, MODE_BLINK, 1'b0, PREDICTED, 8'h00, 8'h00);
		add_cmd(OP_UNUSED, 8'hFF, 2'd3, 5'd31, MODE_OFF, 1'b1, PREDICTED, 8'h00, 8'h00);
		add_cfg(REG_BACKLIGHT, 5'd0);
		add_cmd(OP_PRINT, 8'h5A, 2'd0, 5'd0, MODE_BLINK, 1'b0, TYPED, 8'h51, 8'hA1);
		add_cfg(REG_LINE_COUNT, 5'd4);
		add_cfg(REG_COLUMN_COUNT, 5'd20);
		add_cmd(OP_GOTO, 8'h00, 2'd3, 5'd19, MODE_BLINK, 1'b0, TYPED, 8'hE0, 8'h70);
		add_cmd(OP_PRINT, 8'h7E, 2'd0, 5'd0, MODE_BLINK, 1'b0, PREDICTED, 8'h00, 8'h00);
		// narrow the width under the cursor: printing wraps at once
		add_cmd(OP_GOTO, 8'h00, 2'd0, 5'd19, MODE_BLINK, 1'b0, PREDICTED, 8'h00, 8'h00);
		add_cfg(REG_COLUMN_COUNT, 5'd8);
		add_cmd(OP_PRINT, 8'h30, 2'd0, 5'd0, MODE_BLINK, 1'b0, PREDICTED, 8'h00, 8'h00);
		// newline past the width only moves down
		add_cfg(REG_COLUMN_COUNT, 5'd20);
		add_cmd(OP_GOTO, 8'h00, 2'd1, 5'd19, MODE_BLINK, 1'b0, PREDICTED, 8'h00, 8'h00);
		add_cfg(REG_COLUMN_COUNT, 5'd12);
		add_cmd(OP_PRINT, CHAR_NEWLINE, 2'd0, 5'd0, MODE_BLINK, 1'b0, PREDICTED, 8'h00, 8'h00);
		// out-of-range registers clamp; a full-width newline gives the longest burst
		add_cfg(REG_LINE_COUNT, 5'd0);
		add_cfg(REG_COLUMN_COUNT, 5'd31);
		add_cfg(REG_BACKLIGHT, 5'd1);
		add_cmd(OP_HOME, 8'h00, 2'd0, 5'd0, MODE_BLINK, 1'b0, PREDICTED, 8'h00, 8'h00);
		add_cmd(OP_PRINT, CHAR_NEWLINE, 2'd0, 5'd0, MODE_BLINK, 1'b0, PREDICTED, 8'h00, 8'h00);
		add_cfg(REG_LINE_COUNT, 5'd7);
		add_cfg(REG_COLUMN_COUNT, 5'd0);
		add_cmd(OP_PRINT, 8'h80, 2'd0, 5'd0, MODE_BLINK, 1'b0, PREDICTED, 8'h00, 8'h00);

		tx_idle_pct = 37;
		rx_idle_pct = 87;
		for (int i = 0; i < directed_plan.size(); i++) begin
			row = directed_plan[i];
			if (row.is_cfg) begin
				drain_results();
				write_reg(row.reg_index, row.reg_value);
			end else begin
				send_cmd(row.cmd, row.typed, row.hi, row.lo);
			end
		end

		// Random segments, each with its own register settings and idling pattern
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain_results();
			case (seg)
				0: begin lines_val = 3'd4; cols_val = 5'd20; end
				1: begin lines_val = 3'd1; cols_val = 5'd1; end
				2: begin lines_val = 3'd4; cols_val = 5'd12; end
				3: begin lines_val = 3'd4; cols_val = 5'd16; end
				4: begin
					lines_val = 3'($urandom_range(7));
					cols_val = 5'($urandom_range(31));
				end
				default: begin lines_val = 3'd3; cols_val = 5'd20; end
			endcase
			write_reg(REG_LINE_COUNT, {2'b00, lines_val});
			write_reg(REG_COLUMN_COUNT, cols_val);
			write_reg(REG_BACKLIGHT, 5'($urandom_range(1)));
			tx_idle_pct = (seg < 2) ? 37 : ((seg < 4) ? 87 : 0);
			rx_idle_pct = (seg < 2) ? 87 : ((seg < 4) ? 37 : 0);
			// hold the receiver off while commands keep coming, so the block backs up
			if (seg == 4) stall_asks++;
			for (int n = 0; n < ITEMS_PER_SEGMENT; n++) begin
				send_cmd(random_cmd(), PREDICTED, 8'h00, 8'h00);
			end
		end

		drain_results();
		if (failures == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
